[design/aphf_pkg.sv]
// Shared types, constants and helpers for the attention phase hysteresis unit.
package aphf_pkg;

    // Bin range and widths
    localparam int NUM_BINS = 36;
    localparam int BIN_W    = 6;
    localparam logic [BIN_W:0]   BIN_LIMIT = (BIN_W + 1)'(NUM_BINS);
    localparam logic [BIN_W-1:0] BIN_MAX   = BIN_W'(NUM_BINS - 1);

    localparam int CONF_W  = 16;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 16;

    // Stream payload widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    // Configuration register map (word index)
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_ENGAGE   = 2'd0;
    localparam logic [1:0] REG_RELEASE  = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE = 2'd2;

    localparam logic [CFG_W-1:0] ENGAGE_RST   = 16'd16384;
    localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd9830;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd250;

    // Output phase codes
    localparam logic [1:0] CODE_IDLE    = 2'd0;
    localparam logic [1:0] CODE_ORIENT  = 2'd1;
    localparam logic [1:0] CODE_ENGAGED = 2'd2;
    localparam logic [1:0] CODE_RELEASE = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_ORIENT  = 4'b0010,
        PH_ENGAGED = 4'b0100,
        PH_RELEASE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CONF_W-1:0]  confidence;
        logic [BIN_W-1:0]   bin_idx;
        logic [STAMP_W-1:0] stamp;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] engage_lvl;
        logic [CFG_W-1:0] release_lvl;
        logic [CFG_W-1:0] debounce_time;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic [STAMP_W-1:0] phase_start;
        logic [BIN_W-1:0]   tracked_bin;
        logic               tracked_valid;
        logic [STAMP_W-1:0] target_time;
    } t_state;

    // Map the one-hot phase to its two-bit output code
    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_ORIENT:  code = CODE_ORIENT;
            PH_ENGAGED: code = CODE_ENGAGED;
            default:    code = CODE_RELEASE;
        endcase
        return code;
    endfunction

endpackage

[design/attention_phase_hysteresis_fsm_unit.sv]
// Top level: request stream in, phase machine, result stream out, APB registers.
// Pipeline: a request is registered in the input stage, its result in the result stage.
// Throughput: one request per cycle while the result stage is not held by back-pressure;
// the phase state register closes a loop through the next-state logic.
// Reset (synchronous, active low): phase idle, timers and bin cleared, both
// stages empty, registers back to engage 16384, release 9830, debounce 250.
module attention_phase_hysteresis_fsm_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] confidence, [21:16] bin, [53:22] stamp, [55:54] zero
    input  logic [aphf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] phase, [2] listen, [8:3] held_bin, [9] held_bin_valid,
    // [41:10] engaged_time, [47:42] zero
    output logic [aphf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aphf_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    aphf_pkg::t_cfg   r_cfg;
    aphf_pkg::t_state r_state;
    aphf_pkg::t_state n_state;
    aphf_pkg::t_item  r_in;
    logic             r_in_valid;
    logic             r_out_valid;
    logic [aphf_pkg::OUT_DATA_W-1:0] r_out_data;
    logic             advance;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.engage_lvl    <= aphf_pkg::ENGAGE_RST;
            r_cfg.release_lvl   <= aphf_pkg::RELEASE_RST;
            r_cfg.debounce_time <= aphf_pkg::DEBOUNCE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                aphf_pkg::REG_ENGAGE:   r_cfg.engage_lvl    <= pwdata[15:0];
                aphf_pkg::REG_RELEASE:  r_cfg.release_lvl   <= pwdata[15:0];
                aphf_pkg::REG_DEBOUNCE: r_cfg.debounce_time <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            aphf_pkg::REG_ENGAGE:   prdata = {16'd0, r_cfg.engage_lvl};
            aphf_pkg::REG_RELEASE:  prdata = {16'd0, r_cfg.release_lvl};
            aphf_pkg::REG_DEBOUNCE: prdata = {16'd0, r_cfg.debounce_time};
            default:                prdata = '0;
        endcase
    end

    // Handshake: the input stage moves on when the result stage is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.confidence <= s_axis_tdata[15:0];
            r_in.bin_idx    <= s_axis_tdata[21:16];
            r_in.stamp      <= s_axis_tdata[53:22];
        end
    end

    aphf_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_state (n_state)
    );

    // Phase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= aphf_pkg::PH_IDLE;
            r_state.phase_start   <= '0;
            r_state.tracked_bin   <= '0;
            r_state.tracked_valid <= 1'b0;
            r_state.target_time   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {6'd0,
                           n_state.target_time,
                           n_state.tracked_valid,
                           n_state.tracked_valid ? n_state.tracked_bin : 6'd0,
                           n_state.phase == aphf_pkg::PH_ENGAGED,
                           aphf_pkg::phase_code(n_state.phase)};
        end
    end

    // Engaged is only reachable with a captured bin
    a_engaged_has_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == aphf_pkg::PH_ENGAGED |-> r_state.tracked_valid)
        else $error("engaged phase without a captured bin");

    // A pending result carries the current target time
    a_out_time_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[41:10] == r_state.target_time)
        else $error("result engaged_time differs from state");

    // An empty input stage always takes a request
    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stage empty but not ready");

endmodule

[design/aphf_step.sv]
// Next-state logic of the attention phase machine for one request.
module aphf_step (
    input  aphf_pkg::t_state i_state,
    input  aphf_pkg::t_item  i_item,
    input  aphf_pkg::t_cfg   i_cfg,
    output aphf_pkg::t_state o_state
);

    logic [aphf_pkg::BIN_W-1:0]   bin_sat;
    logic [aphf_pkg::STAMP_W-1:0] start_eff;
    logic [aphf_pkg::STAMP_W-1:0] elapsed;
    logic                         hit_engage;
    logic                         hit_release;
    logic                         debounced;
    logic                         bin_changed;

    // Saturate the bin, fill in an unset phase start, measure elapsed time
    always_comb begin
        bin_sat     = ({1'b0, i_item.bin_idx} >= aphf_pkg::BIN_LIMIT) ?
                      aphf_pkg::BIN_MAX : i_item.bin_idx;
        start_eff   = (i_state.phase_start == '0) ? i_item.stamp : i_state.phase_start;
        elapsed     = i_item.stamp - start_eff;
        hit_engage  = i_item.confidence >= i_cfg.engage_lvl;
        hit_release = i_item.confidence < i_cfg.release_lvl;
        debounced   = elapsed >= {16'd0, i_cfg.debounce_time};
        bin_changed = !i_state.tracked_valid || (bin_sat != i_state.tracked_bin);
    end

    // Phase transitions
    always_comb begin
        o_state             = i_state;
        o_state.phase_start = start_eff;
        case (i_state.phase)
            aphf_pkg::PH_IDLE: begin
                if (hit_engage) begin
                    o_state.phase         = aphf_pkg::PH_ORIENT;
                    o_state.phase_start   = i_item.stamp;
                    o_state.tracked_bin   = bin_sat;
                    o_state.tracked_valid = 1'b1;
                end
            end
            aphf_pkg::PH_ORIENT: begin
                if (hit_release) begin
                    o_state.phase       = aphf_pkg::PH_IDLE;
                    o_state.phase_start = i_item.stamp;
                end else if (bin_changed) begin
                    o_state.tracked_bin   = bin_sat;
                    o_state.tracked_valid = 1'b1;
                    o_state.phase_start   = i_item.stamp;
                end else if (debounced) begin
                    o_state.phase       = aphf_pkg::PH_ENGAGED;
                    o_state.phase_start = i_item.stamp;
                    o_state.target_time = i_item.stamp;
                end
            end
            aphf_pkg::PH_ENGAGED: begin
                if (hit_release) begin
                    o_state.phase       = aphf_pkg::PH_RELEASE;
                    o_state.phase_start = i_item.stamp;
                end else begin
                    o_state.tracked_bin   = bin_sat;
                    o_state.tracked_valid = 1'b1;
                    o_state.target_time   = i_item.stamp;
                end
            end
            default: begin
                if (hit_engage) begin
                    o_state.phase       = aphf_pkg::PH_ORIENT;
                    o_state.phase_start = i_item.stamp;
                end else if (debounced) begin
                    o_state.phase       = aphf_pkg::PH_IDLE;
                    o_state.phase_start = i_item.stamp;
                end
            end
        endcase
    end

endmodule

[test/tb_top.sv]
// Self-checking bench for the attention phase hysteresis unit: streams, APB setup, scoreboard.
`timescale 1ns / 100ps

module tb_top;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [15:0] confidence, [21:16] bin, [53:22] stamp, [55:54] zero
    logic [aphf_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [1:0] phase, [2] listen, [8:3] held_bin, [9] held_bin_valid, [41:10] engaged_time
    logic [aphf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [aphf_pkg::ADDR_W-1:0]     paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    attention_phase_hysteresis_fsm_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Expected content of one result
    typedef struct {
        logic [1:0]  phase;
        logic        listen;
        logic [5:0]  held_bin;
        logic        held_valid;
        logic [31:0] engaged_time;
    } t_phase_result;

    // Phase machine predictor plus queue of results still owed by the block
    class t_phase_board;
        logic [15:0]   engage_thr;
        logic [15:0]   release_thr;
        logic [15:0]   debounce_len;
        logic [1:0]    phase;
        logic [31:0]   phase_start;
        logic [5:0]    tracked_bin;
        logic          tracked_valid;
        logic [31:0]   target_time;
        t_phase_result owed_results[$];
        int            errors;
        int            checked;
        int            engaged_seen;
        int            release_seen;

        function new();
            engage_thr    = aphf_pkg::ENGAGE_RST;
            release_thr   = aphf_pkg::RELEASE_RST;
            debounce_len  = aphf_pkg::DEBOUNCE_RST;
            phase         = aphf_pkg::CODE_IDLE;
            phase_start   = '0;
            tracked_bin   = '0;
            tracked_valid = 1'b0;
            target_time   = '0;
            errors        = 0;
            checked       = 0;
            engaged_seen  = 0;
            release_seen  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                aphf_pkg::REG_ENGAGE:   engage_thr   = value;
                aphf_pkg::REG_RELEASE:  release_thr  = value;
                aphf_pkg::REG_DEBOUNCE: debounce_len = value;
                default: ;
            endcase
        endfunction

        // Advance the phase machine by one accepted request
        function void note_request(logic [15:0] conf, logic [5:0] bin_in, logic [31:0] stamp);
            logic [5:0]    bin;
            logic [31:0]   elapsed;
            t_phase_result r;
            bin = (bin_in >= aphf_pkg::NUM_BINS) ? aphf_pkg::BIN_MAX : bin_in;
            if (phase_start == 32'd0) phase_start = stamp;
            elapsed = stamp - phase_start;
            case (phase)
                aphf_pkg::CODE_IDLE: begin
                    if (conf >= engage_thr) begin
                        phase         = aphf_pkg::CODE_ORIENT;
                        phase_start   = stamp;
                        tracked_bin   = bin;
                        tracked_valid = 1'b1;
                    end
                end
                aphf_pkg::CODE_ORIENT: begin
                    if (conf < release_thr) begin
                        phase       = aphf_pkg::CODE_IDLE;
                        phase_start = stamp;
                    end else if (!tracked_valid || bin != tracked_bin) begin
                        tracked_bin   = bin;
                        tracked_valid = 1'b1;
                        phase_start   = stamp;
                    end else if (elapsed >= {16'd0, debounce_len}) begin
                        phase       = aphf_pkg::CODE_ENGAGED;
                        phase_start = stamp;
                        target_time = stamp;
                    end
                end
                aphf_pkg::CODE_ENGAGED: begin
                    if (conf < release_thr) begin
                        phase       = aphf_pkg::CODE_RELEASE;
                        phase_start = stamp;
                    end else begin
                        tracked_bin   = bin;
                        tracked_valid = 1'b1;
                        target_time   = stamp;
                    end
                end
                default: begin
                    // release: re-orient on a strong target, else drop to idle after debounce
                    if (conf >= engage_thr) begin
                        phase       = aphf_pkg::CODE_ORIENT;
                        phase_start = stamp;
                    end else if (elapsed >= {16'd0, debounce_len}) begin
                        phase       = aphf_pkg::CODE_IDLE;
                        phase_start = stamp;
                    end
                end
            endcase
            r.phase        = phase;
            r.listen       = (phase == aphf_pkg::CODE_ENGAGED);
            r.held_bin     = tracked_valid ? tracked_bin : 6'd0;
            r.held_valid   = tracked_valid;
            r.engaged_time = target_time;
            owed_results.insert(owed_results.size(), r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest owed one
        function void check_result(logic [aphf_pkg::OUT_DATA_W-1:0] data);
            t_phase_result r;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, data);
                return;
            end
            r = owed_results.pop_front();
            checked++;
            if (r.phase == aphf_pkg::CODE_ENGAGED) engaged_seen++;
            if (r.phase == aphf_pkg::CODE_RELEASE) release_seen++;
            compare_field("phase", 32'(r.phase), 32'(data[1:0]));
            compare_field("listen", 32'(r.listen), 32'(data[2]));
            compare_field("held_bin", 32'(r.held_bin), 32'(data[8:3]));
            compare_field("held_bin_valid", 32'(r.held_valid), 32'(data[9]));
            compare_field("engaged_time", r.engaged_time, data[41:10]);
        endfunction
    endclass

    t_phase_board sb = new();
    logic [31:0]  now_ms = '0;
    logic         steady = 1'b0;
    int           settings_run = 1;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 8);
    end

    // Watch both streams
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[15:0], s_axis_tdata[21:16], s_axis_tdata[53:22]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Offer one request and hold it until it is taken
    task automatic send_item(input logic [15:0] conf, input logic [5:0] bin,
                             input logic [31:0] stamp);
        while (!steady && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, stamp, bin, conf};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait for every owed result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [15:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= aphf_pkg::ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {16'd0, want}) begin
            sb.errors++;
            $display("%0t: register %0d readback: expected %0h, actual %0h",
                     $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register, then read it back; the read's setup follows the access directly
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= aphf_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, value);
        read_reg(idx, value);
    endtask

    task automatic set_thresholds(input logic [15:0] engage, input logic [15:0] rel,
                                  input logic [15:0] debounce);
        write_reg(aphf_pkg::REG_ENGAGE, engage);
        write_reg(aphf_pkg::REG_RELEASE, rel);
        write_reg(aphf_pkg::REG_DEBOUNCE, debounce);
        settings_run++;
    endtask

    // Mostly engage/hold/drop episodes on one bin, with raw noise mixed in
    task automatic run_random(input int count);
        int          sent;
        int          hold_n;
        int          drop_n;
        int          i;
        int          dt_max;
        logic [5:0]  bin;
        logic [15:0] hi_floor;
        logic [15:0] lo_ceil;
        sent = 0;
        while (sent < count) begin
            hi_floor = (sb.engage_thr > sb.release_thr) ? sb.engage_thr : sb.release_thr;
            lo_ceil  = (sb.engage_thr < sb.release_thr) ? sb.engage_thr : sb.release_thr;
            dt_max   = sb.debounce_len / 3 + 2;
            if ($urandom_range(99) < 75) begin
                bin    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(35));
                hold_n = $urandom_range(2, 8);
                drop_n = $urandom_range(1, 6);
                for (i = 0; i < hold_n + drop_n; i++) begin
                    now_ms += $urandom_range(dt_max);
                    if (i < hold_n) begin
                        // occasional target jump restarts orienting
                        if ($urandom_range(15) == 0) bin = 6'($urandom_range(35));
                        send_item(16'($urandom_range(hi_floor, 65535)), bin, now_ms);
                    end else begin
                        send_item((lo_ceil == 0) ? 16'd0 : 16'($urandom_range(lo_ceil - 1)),
                                  6'($urandom_range(63)), now_ms);
                    end
                end
                sent += hold_n + drop_n;
            end else begin
                case ($urandom_range(3))
                    0: now_ms = $urandom();
                    1: now_ms = 32'd0;
                    default: now_ms += $urandom_range(dt_max);
                endcase
                send_item(16'($urandom()), 6'($urandom()), now_ms);
                sent++;
            end
        end
    endtask

    initial begin
        logic [15:0] engage;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers
        read_reg(aphf_pkg::REG_ENGAGE, aphf_pkg::ENGAGE_RST);
        read_reg(aphf_pkg::REG_RELEASE, aphf_pkg::RELEASE_RST);
        read_reg(aphf_pkg::REG_DEBOUNCE, aphf_pkg::DEBOUNCE_RST);

        // Directed walk through every phase at reset thresholds
        send_item(16'd0, 6'd0, 32'd0);                   // idle, stamp at unset marker
        send_item(16'd16384, 6'd40, 32'd100);            // engage exactly, bin saturates
        send_item(16'd16384, 6'd35, 32'd200);            // same bin, short of debounce
        send_item(16'd20000, 6'd5, 32'd300);             // bin change restarts timer
        send_item(16'd20000, 6'd5, 32'd549);             // one ms short
        send_item(16'd20000, 6'd5, 32'd550);             // engaged
        send_item(16'hFFFF, 6'd63, 32'd600);             // confidence above 1.0, top bin
        send_item(16'd9829, 6'd0, 32'd700);              // just below release
        send_item(16'd9830, 6'd0, 32'd800);              // release held, not yet idle
        send_item(16'd16384, 6'd1, 32'd900);             // back to orienting, bin kept
        send_item(16'd0, 6'd1, 32'd950);                 // orienting drops to idle
        send_item(16'd32768, 6'd2, 32'hFFFF_FF00);       // orienting near wrap
        send_item(16'd32768, 6'd2, 32'h0000_0010);       // elapsed across wrap
        send_item(16'd100, 6'd2, 32'h0000_0020);         // release
        send_item(16'd100, 6'd2, 32'h0000_0200);         // release times out
        send_item(16'd40000, 6'd7, 32'd0);               // timer restarted at zero
        send_item(16'd40000, 6'd7, 32'd300);             // zero start replaced
        send_item(16'd40000, 6'd7, 32'd550);             // engaged
        send_item(16'd40000, 6'd36, 32'hFFFF_FFFF);      // lowest out-of-range bin
        send_item(16'd0, 6'd36, 32'hFFFF_FFFF);          // release
        now_ms = 32'd1000;
        run_random(100);
        drain();

        // Zero thresholds and no debounce
        set_thresholds(16'd0, 16'd0, 16'd0);
        run_random(100);
        drain();

        // Thresholds beyond 1.0, longest debounce
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(100);
        drain();

        // Both thresholds at 1.0, debounce 1 ms, no idling either side
        steady = 1'b1;
        set_thresholds(16'd32768, 16'd32768, 16'd1);
        run_random(100);
        drain();
        steady = 1'b0;

        // Random working point, with a full pause mid-way
        engage = 16'($urandom_range(8000, 32768));
        set_thresholds(engage, 16'($urandom_range(0, 40000)), 16'($urandom_range(0, 300)));
        run_random(90);
        drain();
        run_random(90);
        drain();

        repeat (10) @(posedge i_clk);
        $display("Checked %0d results over %0d threshold settings", sb.checked, settings_run);
        $display("Results in engaged: %0d, in release: %0d", sb.engaged_seen, sb.release_seen);
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit
    initial begin
        #400000;
        $display("Timeout with %0d results outstanding", sb.owed_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
